/* hdl/nbls_pkg.sv */
// Shared constants, status codes and control structures of the node bucket LIFO scheduler.
// Used by every module of the block but nbls_ram; depends on nothing else.
`timescale 1ns / 1ps

package nbls_pkg;

  localparam int NODES          = 256;
  localparam int BUCKET_DEPTH   = 64;
  localparam int WALKER_ID_BITS = 12;

  localparam int NODE_BITS = $clog2(NODES);
  localparam int FILL_W    = $clog2(BUCKET_DEPTH + 1);
  localparam int IDX_W     = $clog2(BUCKET_DEPTH);
  localparam int DEPTH_W   = $clog2(NODES + 1);
  localparam int WID_W     = (WALKER_ID_BITS < 12) ? WALKER_ID_BITS : 12;
  localparam int BKT_AW    = NODE_BITS + IDX_W;
  localparam int BKT_DEPTH = NODES * (1 << IDX_W);

  localparam int CFG_W       = 9;
  localparam int CMP_W       = 13;
  localparam int NODE_W      = 12;
  localparam int WALKER_W    = 12;
  localparam int PNODE_W     = 8;
  localparam int ALIVE_W     = 15;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(256);
  localparam logic [ALIVE_W-1:0] ALIVE_MAX = {ALIVE_W{1'b1}};

  typedef enum logic [STATUS_W-1:0] {
    ST_WALKER   = 2'd0,
    ST_INS_OK   = 2'd1,
    ST_INS_DROP = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  typedef struct packed {
    logic cap;
    logic ins_do;
    logic emit_empty;
    logic pop_node;
    logic pop_fill;
    logic emit_walker;
  } nbls_cmd_t;

  typedef struct packed {
    logic in_pop;
    logic depth_zero;
    logic fill_zero;
    logic out_free;
    logic last_walker;
  } nbls_sts_t;

endpackage

/* hdl/nbls_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the bucket store, the fill counts and the node stack.
`timescale 1ns / 1ps

module nbls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/nbls_ctrl.sv */
// Sequencing state machine of the node bucket LIFO scheduler.
// Depends on nbls_pkg for the command and status structures.
`timescale 1ns / 1ps

module nbls_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  nbls_pkg::nbls_sts_t sts,
  output nbls_pkg::nbls_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_EMPTY,
    S_POP1,
    S_POP2,
    S_STREAM
  } state_t;

  state_t state_r, state_nxt;
  logic   ready_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && ready_r) begin
          cmd.cap = 1'b1;
          if (!sts.in_pop) begin
            state_nxt = S_INS;
          end else if (sts.depth_zero) begin
            state_nxt = S_EMPTY;
          end else begin
            state_nxt = S_POP1;
          end
        end
      end
      S_INS: begin
        if (sts.out_free) begin
          cmd.ins_do = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          cmd.emit_empty = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_POP1: begin
        cmd.pop_node = 1'b1;
        state_nxt    = S_POP2;
      end
      S_POP2: begin
        cmd.pop_fill = 1'b1;
        state_nxt    = sts.fill_zero ? S_EMPTY : S_STREAM;
      end
      S_STREAM: begin
        if (sts.out_free) begin
          cmd.emit_walker = 1'b1;
          if (sts.last_walker) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ready_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_tready = ready_r;

endmodule

/* hdl/nbls_dp.sv */
// Datapath of the node bucket LIFO scheduler: bucket, fill and stack memories, counters and
// the output register. Depends on nbls_pkg and nbls_ram.
`timescale 1ns / 1ps

module nbls_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [nbls_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                 cfg_we,
  input  logic [nbls_pkg::CFG_W-1:0]           cfg_wdata,
  input  nbls_pkg::nbls_cmd_t                  cmd,
  output nbls_pkg::nbls_sts_t                  sts,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [nbls_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tlast,
  output logic [nbls_pkg::STATUS_W-1:0]        out_tuser
);

  logic                              in_cmd;
  logic [nbls_pkg::WALKER_W-1:0]     in_wid;
  logic [nbls_pkg::NODE_W-1:0]       in_node;
  logic [nbls_pkg::CMP_W-1:0]        limit;
  logic                              in_range;
  logic [nbls_pkg::NODE_BITS-1:0]    node_clamped;

  logic [nbls_pkg::CFG_W-1:0]        nodes_r;
  logic [nbls_pkg::DEPTH_W-1:0]      depth_r;
  logic [nbls_pkg::ALIVE_W-1:0]      alive_r, alive_nxt;
  logic [nbls_pkg::NODE_BITS-1:0]    node_r;
  logic [nbls_pkg::WID_W-1:0]        wid_r;
  logic [nbls_pkg::FILL_W-1:0]       cnt_r;
  logic [nbls_pkg::IDX_W-1:0]        idx_r;
  logic                              valid_r [nbls_pkg::NODES];
  logic                              fvld_r;

  logic                              out_valid_r;
  nbls_pkg::status_t                 out_status_r;
  logic [nbls_pkg::WALKER_W-1:0]     out_walker_r;
  logic [nbls_pkg::PNODE_W-1:0]      out_node_r;
  logic                              out_last_r;
  logic [nbls_pkg::ALIVE_W-1:0]      out_alive_r;

  logic                              fill_re, fill_we;
  logic [nbls_pkg::NODE_BITS-1:0]    fill_raddr;
  logic [nbls_pkg::FILL_W-1:0]       fill_rdata, fill_q;
  logic                              full, ins_commit, push, stk_re;
  logic [nbls_pkg::NODE_BITS-1:0]    stk_rdata;
  logic                              bkt_re;
  logic [nbls_pkg::IDX_W-1:0]        idx_inc;
  logic [nbls_pkg::BKT_AW-1:0]       bkt_raddr;
  logic [nbls_pkg::WID_W-1:0]        bkt_rdata;
  logic                              out_load;

  assign in_cmd  = in_tdata[0];
  assign in_wid  = in_tdata[12:1];
  assign in_node = in_tdata[24:13];

  always_comb begin
    limit = nbls_pkg::CMP_W'(nodes_r);
    if (limit > nbls_pkg::CMP_W'(nbls_pkg::NODES)) begin
      limit = nbls_pkg::CMP_W'(nbls_pkg::NODES);
    end
    if (limit == '0) begin
      limit = nbls_pkg::CMP_W'(1);
    end
  end

  assign in_range     = !in_node[nbls_pkg::NODE_W-1] && (nbls_pkg::CMP_W'(in_node) < limit);
  assign node_clamped = in_range ? in_node[nbls_pkg::NODE_BITS-1:0] : '0;

  assign fill_q      = fvld_r ? fill_rdata : '0;
  assign full        = (fill_q >= nbls_pkg::FILL_W'(nbls_pkg::BUCKET_DEPTH));
  assign ins_commit  = cmd.ins_do && !full;
  assign push        = ins_commit && (fill_q == '0);
  assign stk_re      = cmd.cap && in_cmd && (depth_r != '0);
  assign fill_re     = (cmd.cap && !in_cmd) || cmd.pop_node;
  assign fill_raddr  = cmd.pop_node ? stk_rdata : node_clamped;
  assign fill_we     = ins_commit;
  assign idx_inc     = idx_r + nbls_pkg::IDX_W'(1);
  assign bkt_re      = cmd.pop_fill || (cmd.emit_walker && !sts.last_walker);
  assign bkt_raddr   = cmd.pop_fill ? {node_r, nbls_pkg::IDX_W'(0)} : {node_r, idx_inc};
  assign out_load    = cmd.ins_do || cmd.emit_empty || cmd.emit_walker;

  assign sts.in_pop      = in_cmd;
  assign sts.depth_zero  = (depth_r == '0);
  assign sts.fill_zero   = (fill_q == '0);
  assign sts.out_free    = !out_valid_r || out_tready;
  assign sts.last_walker = ((nbls_pkg::FILL_W'(idx_r) + nbls_pkg::FILL_W'(1)) == cnt_r);

  always_comb begin
    alive_nxt = alive_r;
    if (ins_commit) begin
      if (alive_r != nbls_pkg::ALIVE_MAX) begin
        alive_nxt = alive_r + nbls_pkg::ALIVE_W'(1);
      end
    end else if (cmd.pop_fill) begin
      if (alive_r >= nbls_pkg::ALIVE_W'(fill_q)) begin
        alive_nxt = alive_r - nbls_pkg::ALIVE_W'(fill_q);
      end else begin
        alive_nxt = '0;
      end
    end
  end

  nbls_ram #(
    .WIDTH(nbls_pkg::FILL_W),
    .DEPTH(nbls_pkg::NODES)
  ) u_fill_ram (
    .clk  (clk),
    .we   (fill_we),
    .waddr(node_r),
    .wdata(fill_q + nbls_pkg::FILL_W'(1)),
    .re   (fill_re),
    .raddr(fill_raddr),
    .rdata(fill_rdata)
  );

  nbls_ram #(
    .WIDTH(nbls_pkg::NODE_BITS),
    .DEPTH(nbls_pkg::NODES)
  ) u_stack_ram (
    .clk  (clk),
    .we   (push),
    .waddr(depth_r[nbls_pkg::NODE_BITS-1:0]),
    .wdata(node_r),
    .re   (stk_re),
    .raddr(nbls_pkg::NODE_BITS'(depth_r - nbls_pkg::DEPTH_W'(1))),
    .rdata(stk_rdata)
  );

  nbls_ram #(
    .WIDTH(nbls_pkg::WID_W),
    .DEPTH(nbls_pkg::BKT_DEPTH)
  ) u_bucket_ram (
    .clk  (clk),
    .we   (ins_commit),
    .waddr({node_r, fill_q[nbls_pkg::IDX_W-1:0]}),
    .wdata(wid_r),
    .re   (bkt_re),
    .raddr(bkt_raddr),
    .rdata(bkt_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_r     <= nbls_pkg::CFG_RESET;
      depth_r     <= '0;
      alive_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < nbls_pkg::NODES; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        nodes_r <= cfg_wdata;
      end
      if (stk_re) begin
        depth_r <= depth_r - nbls_pkg::DEPTH_W'(1);
      end else if (push) begin
        depth_r <= depth_r + nbls_pkg::DEPTH_W'(1);
      end
      alive_r <= alive_nxt;
      if (ins_commit) begin
        valid_r[node_r] <= 1'b1;
      end else if (cmd.pop_fill) begin
        valid_r[node_r] <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fill_re) begin
      fvld_r <= valid_r[fill_raddr];
    end
    if (cmd.cap) begin
      node_r <= node_clamped;
      wid_r  <= in_wid[nbls_pkg::WID_W-1:0];
    end else if (cmd.pop_node) begin
      node_r <= stk_rdata;
    end
    if (cmd.pop_fill) begin
      cnt_r <= fill_q;
      idx_r <= '0;
    end else if (cmd.emit_walker) begin
      idx_r <= idx_inc;
    end
    if (cmd.ins_do) begin
      out_status_r <= full ? nbls_pkg::ST_INS_DROP : nbls_pkg::ST_INS_OK;
      out_walker_r <= '0;
      out_node_r   <= '0;
      out_last_r   <= 1'b1;
      out_alive_r  <= alive_nxt;
    end else if (cmd.emit_empty) begin
      out_status_r <= nbls_pkg::ST_NONE;
      out_walker_r <= '0;
      out_node_r   <= '0;
      out_last_r   <= 1'b1;
      out_alive_r  <= alive_r;
    end else if (cmd.emit_walker) begin
      out_status_r <= nbls_pkg::ST_WALKER;
      out_walker_r <= nbls_pkg::WALKER_W'(bkt_rdata);
      out_node_r   <= nbls_pkg::PNODE_W'(node_r);
      out_last_r   <= sts.last_walker;
      out_alive_r  <= alive_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_alive_r, out_node_r, out_walker_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_status_r;

endmodule

/* hdl/node_bucket_lifo_scheduler.sv */
// Node bucket LIFO scheduler top level; joins nbls_ctrl and nbls_dp, depends on nbls_pkg.
// An insert result or an empty pop result is loaded into the output register from state S_INS or
// S_EMPTY once that register is free; a pop reads the stack, then the fill count (S_POP1), then the
// bucket memory (S_POP2), and then gives one walker per cycle while the output register is free.
// A new item is taken only once the previous one is through. Reset is synchronous, active low:
// it clears the stack depth, the alive count and the per-node fill valid bits; no clearing pass.
`timescale 1ns / 1ps

module node_bucket_lifo_scheduler (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // Fields from bit 0: cmd[0], walker_id[12:1], node[24:13], zero pad[31:25].
  input  logic [nbls_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // Fields from bit 0: walker_out[11:0], popped_node[19:12], alive_total[34:20], zero pad.
  output logic [nbls_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast,
  // Fields from bit 0: status[1:0].
  output logic [nbls_pkg::STATUS_W-1:0]    out_tuser,
  input  logic                             cfg_we,
  input  logic [nbls_pkg::CFG_W-1:0]       cfg_wdata
);

  nbls_pkg::nbls_cmd_t cmd;
  nbls_pkg::nbls_sts_t sts;

  nbls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nbls_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

`ifndef SYNTHESIS
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.ins_do, cmd.emit_empty, cmd.emit_walker}))
    else $error("More than one result loaded in one cycle.");

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ins_do || cmd.emit_empty || cmd.emit_walker) |-> sts.out_free)
    else $error("Result loaded while the output register is occupied.");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("New item accepted while the previous one is in progress.");
`endif

endmodule

/* tb/nbls_checker.sv */
// Checker for the node bucket LIFO scheduler: watches the configuration, input and result
// channels, predicts each result item and compares it with what the block delivers.
// Depends on nbls_pkg for widths, node counts and status codes.
`timescale 1ns / 1ps

module nbls_checker
  import nbls_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // Fields from bit 0: cmd[0], walker_id[12:1], node[24:13], zero pad[31:25].
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // Fields from bit 0: walker_out[11:0], popped_node[19:12], alive_total[34:20], zero pad.
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tlast,
  // Fields from bit 0: status[1:0].
  input  logic [STATUS_W-1:0]    out_tuser,
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_wdata,
  output int                     mismatches,
  output int                     awaited
);

  typedef struct packed {
    status_t              status;
    logic [WALKER_W-1:0]  walker;
    logic [PNODE_W-1:0]   pnode;
    logic                 last;
    logic [ALIVE_W-1:0]   alive;
  } sched_result_t;

  logic [WALKER_W-1:0] bucket [NODES][BUCKET_DEPTH];
  int unsigned         fill_of [NODES];
  int unsigned         stack_node [NODES];
  bit                  stacked [NODES];
  int unsigned         depth_q;
  int unsigned         alive_q;
  logic [CFG_W-1:0]    node_cfg;
  sched_result_t       result_q [$];
  int                  err_cnt = 0;

  task automatic schedule_item(input logic [IN_TDATA_W-1:0] d);
    logic                    cmd;
    logic [WALKER_W-1:0]     wid;
    logic signed [NODE_W-1:0] nd;
    int                      lim;
    int unsigned             v;
    int unsigned             f;
    sched_result_t           r;
    cmd = d[0];
    wid = d[12:1];
    nd  = d[24:13];
    r   = '{status: ST_NONE, walker: '0, pnode: '0, last: 1'b1, alive: '0};
    if (cmd == 1'b0) begin
      lim = (node_cfg > NODES) ? NODES : ((node_cfg == 0) ? 1 : int'(node_cfg));
      if (nd < 0 || int'(nd) >= lim) v = 0;
      else v = int'(nd);
      f = fill_of[v];
      if (f >= BUCKET_DEPTH) begin
        r.status = ST_INS_DROP;
      end else begin
        if (f == 0 && !stacked[v] && depth_q < NODES) begin
          stacked[v]          = 1'b1;
          stack_node[depth_q] = v;
          depth_q++;
        end
        bucket[v][f] = wid;
        fill_of[v]   = f + 1;
        if (alive_q < 32767) alive_q++;
        r.status = ST_INS_OK;
      end
      r.alive = ALIVE_W'(alive_q);
      result_q.push_back(r);
    end else if (depth_q == 0) begin
      r.alive = ALIVE_W'(alive_q);
      result_q.push_back(r);
    end else begin
      depth_q--;
      v          = stack_node[depth_q];
      stacked[v] = 1'b0;
      f          = fill_of[v];
      fill_of[v] = 0;
      alive_q    = (alive_q >= f) ? alive_q - f : 0;
      r.alive    = ALIVE_W'(alive_q);
      if (f == 0) begin
        result_q.push_back(r);
      end else begin
        for (int i = 0; i < f; i++) begin
          r.status = ST_WALKER;
          r.walker = bucket[v][i];
          r.pnode  = PNODE_W'(v);
          r.last   = (i == f - 1);
          result_q.push_back(r);
        end
      end
    end
  endtask

  always @(posedge clk) begin : watch
    sched_result_t want;
    sched_result_t got;
    if (!rst_n) begin
      for (int n = 0; n < NODES; n++) begin
        fill_of[n] = 0;
        stacked[n] = 1'b0;
      end
      depth_q  = 0;
      alive_q  = 0;
      node_cfg = CFG_RESET;
      result_q.delete();
    end else begin
      if (cfg_we) node_cfg = cfg_wdata;
      if (in_tvalid && in_tready) schedule_item(in_tdata);
      if (out_tvalid && out_tready) begin
        got = '{status: status_t'(out_tuser), walker: out_tdata[11:0],
                pnode: out_tdata[19:12], last: out_tlast, alive: out_tdata[34:20]};
        if (result_q.size() == 0) begin
          if (err_cnt < 10) begin
            $write("%0t: unexpected result item: status %0d walker %0d ",
                   $time, got.status, got.walker);
            $display("node %0d last %0b alive %0d", got.pnode, got.last, got.alive);
          end
          err_cnt++;
        end else begin
          want = result_q.pop_front();
          if (got != want) begin
            if (err_cnt < 10) begin
              $write("%0t: mismatch: expected status %0d walker %0d node %0d last %0b ",
                     $time, want.status, want.walker, want.pnode, want.last);
              $write("alive %0d, got status %0d walker %0d ",
                     want.alive, got.status, got.walker);
              $display("node %0d last %0b alive %0d", got.pnode, got.last, got.alive);
            end
            err_cnt++;
          end
        end
      end
    end
    mismatches <= err_cnt;
    awaited    <= result_q.size();
  end

endmodule

/* tb/tb_node_bucket_lifo_scheduler.sv */
// Top of the node bucket LIFO scheduler testbench: clock, reset, stimulus and verdict.
// Drives node_bucket_lifo_scheduler and leaves prediction and comparison to nbls_checker.
`timescale 1ns / 1ps

module tb_node_bucket_lifo_scheduler;
  import nbls_pkg::*;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;
  localparam int   LONG_HOLD  = 300;
  localparam int   DRAIN      = 8;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic [STATUS_W-1:0]    out_tuser;
  logic                   cfg_we     = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata  = '0;
  int                     mismatches;
  int                     awaited;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_seen      = 0;
  int stall_left     = 0;
  int cur_nodes      = 256;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  node_bucket_lifo_scheduler u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  nbls_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen  = hold_req;
      stall_left = LONG_HOLD;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(input logic cmd, input logic [11:0] wid, input logic [11:0] node);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, node, wid, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_nodes(input int nodes);
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(nodes);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_nodes = nodes;
  endtask

  function automatic logic [11:0] pick_node(input int span);
    int lim;
    int roll;
    lim  = (cur_nodes > NODES) ? NODES : ((cur_nodes == 0) ? 1 : cur_nodes);
    roll = $urandom_range(99);
    if (roll < 15) return 12'($urandom);
    if (roll < 25) return 12'(lim - 1 + $urandom_range(1));
    return 12'($urandom_range(span - 1));
  endfunction

  task automatic run_phase(input int nodes, input int send_pct, input int recv_pct,
                           input int count, input int pop_pct, input int span,
                           input bit long_hold);
    wait_idle();
    write_nodes(nodes);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (long_hold) hold_req++;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < pop_pct) send_item(CMD_POP, 12'($urandom), 12'($urandom));
      else send_item(CMD_INSERT, 12'($urandom), pick_node(span));
    end
  endtask

  initial begin
    #(300_000 * 12);
    $display("** node_bucket_lifo_scheduler: FAILED **");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Boundary nodes at the reset node count, including negative and clamped nodes.
    send_item(CMD_POP, 12'hFFF, 12'hFFF);
    send_item(CMD_INSERT, 12'd0, 12'd0);
    send_item(CMD_INSERT, 12'hFFF, 12'd255);
    send_item(CMD_INSERT, 12'd1, 12'd256);
    send_item(CMD_INSERT, 12'd2, 12'hFFF);
    send_item(CMD_INSERT, 12'd3, 12'h800);
    send_item(CMD_INSERT, 12'd4, 12'h7FF);
    send_item(CMD_INSERT, 12'd5, 12'd255);
    send_item(CMD_INSERT, 12'd6, 12'd7);
    repeat (4) send_item(CMD_POP, 12'd0, 12'd0);

    // A node count of zero behaves as one node.
    wait_idle();
    write_nodes(0);
    send_item(CMD_INSERT, 12'hABC, 12'd5);
    send_item(CMD_INSERT, 12'h543, 12'd0);
    repeat (2) send_item(CMD_POP, 12'd0, 12'd0);

    // A node count above the node array behaves as the full array.
    wait_idle();
    write_nodes(511);
    send_item(CMD_INSERT, 12'h111, 12'd300);
    send_item(CMD_INSERT, 12'h222, 12'd255);
    repeat (3) send_item(CMD_POP, 12'd0, 12'd0);

    run_phase(256, 0, 0, 20, 30, 8, 1'b0);

    // One node only: overfill its bucket, then pop all of it.
    wait_idle();
    write_nodes(1);
    send_idle_pct  = 15;
    recv_stall_pct = 15;
    repeat (70) send_item(CMD_INSERT, 12'($urandom), 12'($urandom));
    send_item(CMD_POP, 12'($urandom), 12'($urandom));

    run_phase(2, 49, 0, 40, 25, 2, 1'b0);
    run_phase($urandom_range(256, 1), 0, 49, 40, 30, 6, 1'b1);
    run_phase(511, 15, 15, 40, 35, 16, 1'b0);
    run_phase(0, 0, 0, 30, 20, 1, 1'b0);
    run_phase(256, 0, 49, 30, 30, 256, 1'b0);
    run_phase(255, 15, 15, 30, 40, 4, 1'b0);

    wait_idle();
    if (mismatches == 0) begin
      $display("** node_bucket_lifo_scheduler: PASSED **");
    end else begin
      $display("** node_bucket_lifo_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
